[rtl/cle_pkg.sv]
package cle_pkg;

    localparam int CHAR_W = 7;
    localparam int KEY_W  = 8;

    localparam logic [KEY_W-1:0] KEY_CODE_RIGHT = 8'h3E;
    localparam logic [KEY_W-1:0] KEY_CODE_LEFT  = 8'h3C;
    localparam logic [KEY_W-1:0] KEY_CODE_BACK  = 8'h2D;
    localparam logic [KEY_W-1:0] KEY_CODE_A     = 8'h41;
    localparam logic [KEY_W-1:0] KEY_CODE_Z     = 8'h5A;

    typedef enum logic [2:0] {
        KEY_NONE,
        KEY_RIGHT,
        KEY_LEFT,
        KEY_BACK,
        KEY_INSERT
    } key_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RIGHT_WR,
        ST_LEFT_WR,
        ST_FLUSH_RD,
        ST_FLUSH_LD,
        ST_FLUSH_OUT,
        ST_END_OUT
    } cle_state_t;

    typedef struct packed {
        logic rd_right;
        logic rd_left;
        logic wr_right;
        logic wr_left;
        logic backspace;
        logic insert;
        logic load_char;
        logic load_end;
        logic idx_inc;
        logic clear;
        logic out_valid;
        logic in_ready;
    } cle_cmd_t;

    typedef struct packed {
        key_class_t key_class;
        logic       flush;
        logic       has_left;
        logic       has_right;
        logic       idx_done;
    } cle_status_t;

    function automatic key_class_t decode_key(input logic [KEY_W-1:0] key);
        key_class_t k;
        k = KEY_NONE;
        if (key == KEY_CODE_RIGHT) begin
            k = KEY_RIGHT;
        end else if (key == KEY_CODE_LEFT) begin
            k = KEY_LEFT;
        end else if (key == KEY_CODE_BACK) begin
            k = KEY_BACK;
        end else if (key >= KEY_CODE_A && key <= KEY_CODE_Z) begin
            k = KEY_INSERT;
        end
        return k;
    endfunction

endpackage

[rtl/cle_ram.sv]
module cle_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 63
) (
    input  logic                               aclk,
    input  logic                               we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                   wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                   rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[rtl/cle_ctrl.sv]
module cle_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 m_ready,
    input  cle_pkg::cle_status_t st,
    output cle_pkg::cle_cmd_t    cmd
);

    cle_pkg::cle_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cle_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cle_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (st.flush) begin
                        state_next = cle_pkg::ST_FLUSH_RD;
                    end else if (st.key_class == cle_pkg::KEY_RIGHT && st.has_right) begin
                        state_next = cle_pkg::ST_RIGHT_WR;
                    end else if (st.key_class == cle_pkg::KEY_LEFT && st.has_left) begin
                        state_next = cle_pkg::ST_LEFT_WR;
                    end
                end
            end
            cle_pkg::ST_RIGHT_WR: state_next = cle_pkg::ST_IDLE;
            cle_pkg::ST_LEFT_WR:  state_next = cle_pkg::ST_IDLE;
            cle_pkg::ST_FLUSH_RD: begin
                if (st.idx_done) begin
                    state_next = cle_pkg::ST_END_OUT;
                end else begin
                    state_next = cle_pkg::ST_FLUSH_LD;
                end
            end
            cle_pkg::ST_FLUSH_LD: state_next = cle_pkg::ST_FLUSH_OUT;
            cle_pkg::ST_FLUSH_OUT: begin
                if (m_ready) begin
                    state_next = cle_pkg::ST_FLUSH_RD;
                end
            end
            cle_pkg::ST_END_OUT: begin
                if (m_ready) begin
                    state_next = cle_pkg::ST_IDLE;
                end
            end
            default: state_next = cle_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            cle_pkg::ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_valid && !st.flush) begin
                    cmd.rd_right  = (st.key_class == cle_pkg::KEY_RIGHT) && st.has_right;
                    cmd.rd_left   = (st.key_class == cle_pkg::KEY_LEFT) && st.has_left;
                    cmd.backspace = (st.key_class == cle_pkg::KEY_BACK);
                    cmd.insert    = (st.key_class == cle_pkg::KEY_INSERT);
                end
            end
            cle_pkg::ST_RIGHT_WR: cmd.wr_right = 1'b1;
            cle_pkg::ST_LEFT_WR:  cmd.wr_left = 1'b1;
            cle_pkg::ST_FLUSH_RD: begin
                cmd.load_end = st.idx_done;
            end
            cle_pkg::ST_FLUSH_LD: cmd.load_char = 1'b1;
            cle_pkg::ST_FLUSH_OUT: begin
                cmd.out_valid = 1'b1;
                cmd.idx_inc   = m_ready;
            end
            cle_pkg::ST_END_OUT: begin
                cmd.out_valid = 1'b1;
                cmd.clear     = m_ready;
            end
            default: cmd = '0;
        endcase
    end

endmodule

[rtl/cle_dp.sv]
module cle_dp #(
    parameter int DEPTH = 63
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cle_pkg::cle_cmd_t          cmd,
    input  logic [cle_pkg::KEY_W-1:0]  s_key,
    input  logic                       s_flush,
    output cle_pkg::cle_status_t       st,
    output logic [cle_pkg::KEY_W-1:0]  m_out_char,
    output logic                       m_cursor_before,
    output logic                       m_end_item,
    output logic                       m_overflow_seen,
    output logic                       m_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] right_reg, right_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          ovf_reg, ovf_next;

    logic [cle_pkg::KEY_W-1:0] char_reg;
    logic                      cur_reg, end_reg, last_reg;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [cle_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;

    logic [CW:0] total;
    logic [CW:0] flush_addr;
    logic        full;

    assign total = {1'b0, left_reg} + {1'b0, right_reg};
    assign full  = (total == DEPTH_W);

    // Right-part entries sit at DEPTH - right + (idx - left).
    assign flush_addr = (idx_reg < left_reg) ? {1'b0, idx_reg}
                      : DEPTH_W - total + {1'b0, idx_reg};

    always_comb begin
        ram_raddr = flush_addr[AW-1:0];
        if (cmd.rd_right) begin
            ram_raddr = AW'(DEPTH_W - {1'b0, right_reg});
        end else if (cmd.rd_left) begin
            ram_raddr = AW'({1'b0, left_reg} - 1'b1);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = left_reg[AW-1:0];
        ram_wdata = ram_rdata;
        if (cmd.wr_right) begin
            ram_we = 1'b1;
        end else if (cmd.wr_left) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(DEPTH_W - 1'b1 - {1'b0, right_reg});
        end else if (cmd.insert && !full) begin
            ram_we    = 1'b1;
            ram_wdata = s_key[cle_pkg::CHAR_W-1:0];
        end
    end

    cle_ram #(
        .WIDTH (cle_pkg::CHAR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        left_next  = left_reg;
        right_next = right_reg;
        idx_next   = idx_reg;
        ovf_next   = ovf_reg;
        if (cmd.wr_right) begin
            left_next  = left_reg + 1'b1;
            right_next = right_reg - 1'b1;
        end
        if (cmd.wr_left) begin
            left_next  = left_reg - 1'b1;
            right_next = right_reg + 1'b1;
        end
        if (cmd.backspace && left_reg != '0) begin
            left_next = left_reg - 1'b1;
        end
        if (cmd.insert) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                left_next = left_reg + 1'b1;
            end
        end
        if (cmd.idx_inc) begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.clear) begin
            left_next  = '0;
            right_next = '0;
            idx_next   = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg  <= '0;
            right_reg <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            left_reg  <= left_next;
            right_reg <= right_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_char) begin
            char_reg <= {1'b0, ram_rdata};
            cur_reg  <= (idx_reg == left_reg);
            end_reg  <= 1'b0;
            last_reg <= 1'b0;
        end else if (cmd.load_end) begin
            char_reg <= '0;
            cur_reg  <= (right_reg == '0);
            end_reg  <= 1'b1;
            last_reg <= 1'b1;
        end
    end

    assign st.key_class = cle_pkg::decode_key(s_key);
    assign st.flush     = s_flush;
    assign st.has_left  = (left_reg != '0);
    assign st.has_right = (right_reg != '0);
    assign st.idx_done  = ({1'b0, idx_reg} == total);

    assign m_out_char      = char_reg;
    assign m_cursor_before = cur_reg;
    assign m_end_item      = end_reg;
    assign m_overflow_seen = ovf_reg;
    assign m_last          = last_reg;

endmodule

[rtl/cursor_line_editor.sv]
// Edit keys: a move request reads the buffer, then writes it; others finish in idle.
// Flush: each character is read via the single read port of the text RAM, then loaded
// and output (output may stall), then one end item: up to DEPTH+1 results per flush request.
// Reset (aresetn low, synchronous) empties the line and clears the overflow flag;
// the text RAM itself is not cleared.
module cursor_line_editor #(
    parameter int DEPTH = 63
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_key,
    input  logic       s_flush,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_cursor_before,
    output logic       m_end_item,
    output logic       m_overflow_seen,
    output logic       m_last
);

    cle_pkg::cle_cmd_t    cmd;
    cle_pkg::cle_status_t st;

    cle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    cle_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_key           (s_key),
        .s_flush         (s_flush),
        .st              (st),
        .m_out_char      (m_out_char),
        .m_cursor_before (m_cursor_before),
        .m_end_item      (m_end_item),
        .m_overflow_seen (m_overflow_seen),
        .m_last          (m_last)
    );

    assign s_ready = cmd.in_ready;
    assign m_valid = cmd.out_valid;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == m_end_item))
        else $error("last flag and end item disagree");

    a_cleared_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (!st.has_left && !st.has_right && s_ready))
        else $error("line not cleared after read-out");

endmodule

[test/line_checker.sv]
module line_checker #(
    parameter int DEPTH = 63
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_key,
    input  logic       s_flush,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_char,
    input  logic       m_cursor_before,
    input  logic       m_end_item,
    input  logic       m_overflow_seen,
    input  logic       m_last,
    output int         fail_count,
    output int         pending,
    output int         results_checked,
    output int         overflow_runs
);

    typedef struct packed {
        logic [7:0] ch;
        logic       cur;
        logic       fin;
        logic       ovf;
        logic       lst;
    } line_item_t;

    logic [cle_pkg::CHAR_W-1:0] gap_text [DEPTH];
    int unsigned                n_left = 0;
    int unsigned                n_right = 0;
    logic                       dropped = 1'b0;
    line_item_t                 line_q [$];
    int                         mismatches = 0;
    int                         checked = 0;
    int                         ovf_lines = 0;

    function automatic cle_pkg::key_class_t classify(input logic [7:0] k);
        cle_pkg::key_class_t c;
        c = cle_pkg::KEY_NONE;
        if (k == cle_pkg::KEY_CODE_RIGHT) begin
            c = cle_pkg::KEY_RIGHT;
        end else if (k == cle_pkg::KEY_CODE_LEFT) begin
            c = cle_pkg::KEY_LEFT;
        end else if (k == cle_pkg::KEY_CODE_BACK) begin
            c = cle_pkg::KEY_BACK;
        end else if (k >= cle_pkg::KEY_CODE_A && k <= cle_pkg::KEY_CODE_Z) begin
            c = cle_pkg::KEY_INSERT;
        end
        return c;
    endfunction

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        mismatches++;
        if (mismatches <= 30) begin
            $display("mismatch at result %0d: %s is %h, expected %h", checked, what, got, want);
        end
    endtask

    task automatic edit_line(input logic [7:0] k);
        case (classify(k))
            cle_pkg::KEY_RIGHT: begin
                if (n_right > 0) begin
                    gap_text[n_left] = gap_text[DEPTH - n_right];
                    n_left++;
                    n_right--;
                end
            end
            cle_pkg::KEY_LEFT: begin
                if (n_left > 0) begin
                    gap_text[DEPTH - 1 - n_right] = gap_text[n_left - 1];
                    n_left--;
                    n_right++;
                end
            end
            cle_pkg::KEY_BACK: begin
                if (n_left > 0) begin
                    n_left--;
                end
            end
            cle_pkg::KEY_INSERT: begin
                if (n_left + n_right >= DEPTH) begin
                    dropped = 1'b1;
                end else begin
                    gap_text[n_left] = k[cle_pkg::CHAR_W-1:0];
                    n_left++;
                end
            end
            default: ;
        endcase
    endtask

    task automatic read_out_line();
        line_item_t it;
        for (int i = 0; i < n_left; i++) begin
            it = '{ch: {1'b0, gap_text[i]}, cur: 1'b0, fin: 1'b0, ovf: dropped, lst: 1'b0};
            line_q.push_back(it);
        end
        for (int i = 0; i < n_right; i++) begin
            it = '{ch: {1'b0, gap_text[DEPTH - n_right + i]}, cur: (i == 0), fin: 1'b0,
                   ovf: dropped, lst: 1'b0};
            line_q.push_back(it);
        end
        it = '{ch: 8'h00, cur: (n_right == 0), fin: 1'b1, ovf: dropped, lst: 1'b1};
        line_q.push_back(it);
        if (dropped) begin
            ovf_lines++;
        end
        n_left = 0;
        n_right = 0;
        dropped = 1'b0;
    endtask

    always @(posedge aclk) begin
        line_item_t want;
        if (!aresetn) begin
            n_left = 0;
            n_right = 0;
            dropped = 1'b0;
            line_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                checked++;
                if (line_q.size() == 0) begin
                    report("result with no request behind it, out_char", m_out_char, 8'h00);
                end else begin
                    want = line_q.pop_front();
                    if (m_out_char !== want.ch) begin
                        report("out_char", m_out_char, want.ch);
                    end
                    if (m_cursor_before !== want.cur) begin
                        report("cursor_before", {7'b0, m_cursor_before}, {7'b0, want.cur});
                    end
                    if (m_end_item !== want.fin) begin
                        report("end_item", {7'b0, m_end_item}, {7'b0, want.fin});
                    end
                    if (m_overflow_seen !== want.ovf) begin
                        report("overflow_seen", {7'b0, m_overflow_seen}, {7'b0, want.ovf});
                    end
                    if (m_last !== want.lst) begin
                        report("last", {7'b0, m_last}, {7'b0, want.lst});
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_flush) begin
                    read_out_line();
                end else begin
                    edit_line(s_key);
                end
            end
        end
        fail_count <= mismatches;
        pending <= line_q.size();
        results_checked <= checked;
        overflow_runs <= ovf_lines;
    end

endmodule

[test/tb_top.sv]
module tb_top;

    localparam int DEPTH = 63;
    localparam int RANDOM_REQUESTS = 350;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 300;
    localparam int LONG_HOLD = 600;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_key = 8'h00;
    logic       s_flush = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_char;
    logic       m_cursor_before;
    logic       m_end_item;
    logic       m_overflow_seen;
    logic       m_last;

    int fail_count;
    int pending;
    int results_checked;
    int overflow_runs;

    int cycles = 0;
    int sent = 0;
    int flushes = 0;
    int effective = 0;
    int rx_count = 0;

    cursor_line_editor #(.DEPTH(DEPTH)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key           (s_key),
        .s_flush         (s_flush),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_cursor_before (m_cursor_before),
        .m_end_item      (m_end_item),
        .m_overflow_seen (m_overflow_seen),
        .m_last          (m_last)
    );

    line_checker #(.DEPTH(DEPTH)) chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key           (s_key),
        .s_flush         (s_flush),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_cursor_before (m_cursor_before),
        .m_end_item      (m_end_item),
        .m_overflow_seen (m_overflow_seen),
        .m_last          (m_last),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .overflow_runs   (overflow_runs)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("cursor_line_editor: mismatch");
        $finish;
    end

    task automatic send_item(input logic [7:0] k, input logic f);
        int gap;
        gap = (((sent / 40) % 4) == 2) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_key <= k;
        s_flush <= f;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sent++;
        if (f) begin
            flushes++;
        end
        if (f || k == cle_pkg::KEY_CODE_RIGHT || k == cle_pkg::KEY_CODE_LEFT
                || k == cle_pkg::KEY_CODE_BACK
                || (k >= cle_pkg::KEY_CODE_A && k <= cle_pkg::KEY_CODE_Z)) begin
            effective++;
        end
    endtask

    function automatic logic [7:0] any_letter();
        return cle_pkg::KEY_CODE_A + 8'($urandom_range(0, 25));
    endfunction

    // The receiver draws a wait per result, runs without waits in some stretches,
    // and once holds off long enough for a whole read-out to back up into the input.
    initial begin
        int w;
        bit long_done;
        long_done = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            w = (((rx_count / 96) % 3) == 1) ? 0 : $urandom_range(0, 14);
            if (!long_done && rx_count >= 40) begin
                w = LONG_HOLD;
                long_done = 1'b1;
            end
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            rx_count++;
        end
    end

    initial begin
        int mode;
        int len;
        int r;
        int seq;
        logic [7:0] k;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Moves and backspace on an empty line, then a read-out of the empty line.
        send_item(cle_pkg::KEY_CODE_LEFT, 1'b0);
        send_item(cle_pkg::KEY_CODE_BACK, 1'b0);
        send_item(cle_pkg::KEY_CODE_RIGHT, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(cle_pkg::KEY_CODE_A, 1'b0);
        send_item(cle_pkg::KEY_CODE_Z, 1'b0);
        send_item(cle_pkg::KEY_CODE_A - 8'd1, 1'b0);
        send_item(cle_pkg::KEY_CODE_Z + 8'd1, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item("M", 1'b0);
        send_item(cle_pkg::KEY_CODE_RIGHT, 1'b0);
        send_item(cle_pkg::KEY_CODE_LEFT, 1'b0);
        send_item(cle_pkg::KEY_CODE_LEFT, 1'b0);
        send_item(cle_pkg::KEY_CODE_BACK, 1'b0);
        send_item("Q", 1'b0);
        send_item(cle_pkg::KEY_CODE_RIGHT, 1'b0);
        send_item("K", 1'b1);
        send_item("B", 1'b0);
        send_item(cle_pkg::KEY_CODE_LEFT, 1'b0);
        send_item(8'hFF, 1'b1);

        effective = 0;
        seq = 0;
        while (effective < RANDOM_REQUESTS) begin
            mode = (seq == 0) ? 1 : $urandom_range(0, 11);
            if (mode == 0) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
                end
            end else if (mode == 1) begin
                // Fill the line past its capacity with a few cursor moves mixed in.
                len = DEPTH + $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_item(cle_pkg::KEY_CODE_LEFT, 1'b0);
                    end
                    send_item(any_letter(), 1'b0);
                end
                send_item(cle_pkg::KEY_CODE_BACK, 1'b0);
                send_item(any_letter(), 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                len = $urandom_range(1, 14);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 45) begin
                        k = any_letter();
                    end else if (r < 62) begin
                        k = cle_pkg::KEY_CODE_LEFT;
                    end else if (r < 77) begin
                        k = cle_pkg::KEY_CODE_RIGHT;
                    end else if (r < 87) begin
                        k = cle_pkg::KEY_CODE_BACK;
                    end else begin
                        k = 8'($urandom_range(0, 255));
                    end
                    send_item(k, 1'b0);
                end
                if ($urandom_range(0, 3) != 0) begin
                    send_item(8'($urandom_range(0, 255)), 1'b1);
                end
            end
            seq++;
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests including %0d flushes; %0d results checked.",
                 sent, flushes, results_checked);
        $display("%0d read-outs carried a dropped insert; one long receiver hold-off of %0d cycles.",
                 overflow_runs, LONG_HOLD);
        if (fail_count == 0 && pending == 0) begin
            $display("cursor_line_editor: match");
        end else begin
            $display("cursor_line_editor: mismatch");
        end
        $finish;
    end

endmodule
